// File: design/wsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants for the waveform level store resampler.
// ----------------------------------------------------------------------------
package wsr_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int MAX_POINTS_DEF = 64;
  localparam logic [6:0] POINTS_RESET = 7'd64;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_CLEAR   = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;
  localparam logic [1:0] ACT_LOOKUP  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] sample_time;
    logic [15:0]        sample_rms;
    logic [15:0]        sample_peak;
    logic signed [63:0] query_time;
    logic signed [63:0] range_start;
    logic signed [63:0] range_end;
  } item_t;

  typedef struct packed {
    logic [9:0]         index;
    logic [15:0]        rms_level;
    logic [15:0]        peak_level;
    logic signed [63:0] entry_time;
    logic [15:0]        max_rms;
    logic [15:0]        max_peak;
    logic [15:0]        average_rms;
    logic [10:0]        entry_count;
    logic               status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [63:0] etime;
    logic [15:0]        rms;
    logic [15:0]        peak;
  } entry_t;

endpackage

// File: design/wsr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsr_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsr_mem #(
  parameter int DEPTH = wsr_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  wsr_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output wsr_pkg::entry_t     rd_data
);
  import wsr_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/wsr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsr_div #(
  parameter int NW = 64,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  import wsr_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dvs;
  logic [DW:0]     shifted;
  logic            fits;

  assign shifted = {rem, quo[NW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      // strobe on the last quotient bit
      done <= !go && (cnt == CNTW'(1));
      if (go) begin
        cnt <= CNTW'(NW);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (cnt != '0) begin
        // remainder stays below divisor, so the low DW bits hold it
        rem <= fits ? DW'(shifted - {1'b0, dvs}) : shifted[DW-1:0];
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: design/waveform_level_store_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_level_store_resampler
// Time-ordered level store with lower-bound lookup and display resampling.
// ----------------------------------------------------------------------------
// Issue a transaction with start while busy is low. Results come out one per
// done strobe and cannot be stalled; last marks the final one of a
// transaction. Clear, a dropped append and a lookup on an empty store give
// their result straight from the idle state. Append waits on the bit-serial
// divider that refreshes the average. Lookup is a binary search paced by the
// single read port of the entry store. A display query first divides
// range/points in the divider, then runs one lookup per point; an empty store
// or empty window gives one zero point per cycle. No memory clearing pass is
// needed: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module waveform_level_store_resampler #(
  parameter int CAPACITY   = wsr_pkg::CAPACITY_DEF,
  parameter int MAX_POINTS = wsr_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wsr_pkg::item_t   item,
  input  logic             wr_en,
  input  logic [6:0]       wr_data,
  output logic             done,
  output wsr_pkg::result_t result
);
  import wsr_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int TW  = 16 + CW;          // running RMS sum
  localparam int DVW = (CW > 7) ? CW : 7; // divisor width

  typedef enum logic [3:0] {
    S_IDLE, S_GO, S_DIV, S_PROBE, S_CHECK, S_FETCH, S_ZERO
  } state_t;

  state_t          state;
  item_t           cur;
  logic [6:0]      points_reg;   // config register
  logic [6:0]      pts;          // clamped point count for this transaction
  logic [6:0]      pt_idx;
  logic [CW-1:0]   count;
  logic [15:0]     hi_rms, hi_peak, avg;
  logic [TW-1:0]   total;
  logic [AW-1:0]   lo, hi, mid;
  logic signed [63:0] tgt;       // target time of current search
  logic [63:0]     step_q;
  logic [DVW-1:0]  step_r, acc_r;

  // clamped point count, and window check
  logic [6:0]      pts_clamp;
  logic            win_ok;
  logic [AW:0]     mid_sum;

  // memory
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_ra;
  entry_t          mem_wd, mem_rd;

  // divider
  logic            div_go, div_done;
  logic [63:0]     div_n, div_q;
  logic [DVW-1:0]  div_d, div_r;

  // stepping of the display target time
  logic [DVW:0]    acc_sum;
  logic            acc_carry;

  always_comb begin
    pts_clamp = points_reg;
    if (points_reg == 7'd0) begin
      pts_clamp = 7'd1;
    end else if (points_reg > 7'(MAX_POINTS)) begin
      pts_clamp = 7'(MAX_POINTS);
    end
  end

  assign win_ok  = (count != '0) && (item.range_start < item.range_end);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign busy    = (state != S_IDLE);

  assign acc_sum   = {1'b0, acc_r} + {1'b0, step_r};
  assign acc_carry = acc_sum >= {{(DVW - 6){1'b0}}, pts};

  assign mem_we = (state == S_IDLE) && start && (item.action == ACT_APPEND)
                  && (count != CW'(CAPACITY));
  assign mem_wd = '{etime: item.sample_time, rms: item.sample_rms,
                    peak: item.sample_peak};
  assign mem_re = (state == S_PROBE);
  assign mem_ra = (lo < hi) ? mid_sum[AW:1] : lo;

  // append refreshes the average; display divides the window by points
  assign div_go = (state == S_GO);
  assign div_n  = (cur.action == ACT_APPEND) ? 64'(total)
                                              : 64'(cur.range_end - cur.range_start);
  assign div_d  = (cur.action == ACT_APPEND) ? DVW'(count) : DVW'(pts);

  wsr_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  wsr_div #(.NW(64), .DW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    result_t res;   // result fields built up this cycle
    logic    fire;  // result strobe for this cycle
    if (rst) begin
      state      <= S_IDLE;
      points_reg <= POINTS_RESET;
      count      <= '0;
      hi_rms     <= '0;
      hi_peak    <= '0;
      total      <= '0;
      avg        <= '0;
      done       <= 1'b0;
    end else begin
      res  = result;
      fire = 1'b0;
      if (wr_en) begin
        points_reg <= wr_data;
      end
      // common fields of every result track the current state
      res.max_rms     = hi_rms;
      res.max_peak    = hi_peak;
      res.average_rms = avg;
      res.entry_count = 11'(count);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= item;
            pts    <= pts_clamp;
            pt_idx <= '0;
            lo     <= '0;
            hi     <= AW'(count - 1'b1);
            tgt    <= item.query_time;
            res = '{default: '0, max_rms: hi_rms, max_peak: hi_peak,
                    average_rms: avg, entry_count: 11'(count), last: 1'b1};
            unique case (item.action)
              ACT_APPEND: begin
                if (count == CW'(CAPACITY)) begin
                  res.status = 1'b1;
                  fire       = 1'b1;
                end else begin
                  count <= count + 1'b1;
                  total <= total + TW'(item.sample_rms);
                  if (item.sample_rms > hi_rms) hi_rms <= item.sample_rms;
                  if (item.sample_peak > hi_peak) hi_peak <= item.sample_peak;
                  state <= S_GO;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                total <= '0;
                hi_rms <= '0;
                hi_peak <= '0;
                avg <= '0;
                res.max_rms     = '0;
                res.max_peak    = '0;
                res.average_rms = '0;
                res.entry_count = '0;
                fire = 1'b1;
              end
              ACT_LOOKUP: begin
                if (count == '0) begin
                  fire = 1'b1;
                end else begin
                  state <= S_PROBE;
                end
              end
              default: begin // display
                state <= win_ok ? S_GO : S_ZERO;
              end
            endcase
          end
        end
        S_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (cur.action == ACT_APPEND) begin
              avg    <= 16'(div_q);
              res.average_rms = 16'(div_q);
              res.last = 1'b1;
              fire     = 1'b1;
              state  <= S_IDLE;
            end else begin
              step_q <= div_q;
              step_r <= div_r;
              acc_r  <= '0;
              tgt    <= cur.range_start;
              state  <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          mid   <= mid_sum[AW:1];
          state <= (lo < hi) ? S_CHECK : S_FETCH;
        end
        S_CHECK: begin
          if (mem_rd.etime < tgt) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_FETCH: begin
          fire = 1'b1;
          res.rms_level = mem_rd.rms;
          res.status    = 1'b0;
          if (cur.action == ACT_LOOKUP) begin
            res.index      = 10'(lo);
            res.peak_level = mem_rd.peak;
            res.entry_time = mem_rd.etime;
            res.last       = 1'b1;
            state <= S_IDLE;
          end else begin
            res.index      = 10'(pt_idx);
            res.peak_level = '0;
            res.entry_time = '0;
            res.last       = (pt_idx == pts - 1'b1);
            if (pt_idx == pts - 1'b1) begin
              state <= S_IDLE;
            end else begin
              // next target: start + floor(range*i/points), stepped
              pt_idx <= pt_idx + 1'b1;
              acc_r  <= acc_carry ? DVW'(acc_sum - {{(DVW - 6){1'b0}}, pts})
                                  : acc_sum[DVW-1:0];
              tgt    <= tgt + $signed(step_q) + 64'(acc_carry);
              lo     <= '0;
              hi     <= AW'(count - 1'b1);
              state  <= S_PROBE;
            end
          end
        end
        S_ZERO: begin
          fire = 1'b1;
          res.index      = 10'(pt_idx);
          res.rms_level  = '0;
          res.peak_level = '0;
          res.entry_time = '0;
          res.status     = 1'b0;
          res.last       = (pt_idx == pts - 1'b1);
          pt_idx <= pt_idx + 1'b1;
          if (pt_idx == pts - 1'b1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      result <= res;
      done   <= fire;
    end
  end

endmodule
